/* rtl/core/stt_pkg.sv */
package stt_pkg;

  localparam int SLOTS_DEF = 8;
  localparam int CNT_W     = 32;
  localparam int HND_W     = 4;
  localparam int FUNC_W    = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK   = 3'd0,
    FN_CREATE = 3'd1,
    FN_SETPER = 3'd2,
    FN_RELOAD = 3'd3,
    FN_DELETE = 3'd4
  } func_t;

  // write enables of the slot memories
  typedef struct packed {
    logic per;
    logic dl;
  } mem_we_t;

endpackage

/* rtl/core/software_timer_table.sv */
// Table of SLOTS software timers on a free-running 32-bit tick count. Commands arrive as
// items with the operation in in_tuser; a tick walks the slots one at a time, a read and
// a check state per slot on the period/deadline memory read port, then an end state; an
// output stall can hold it. A create searches for the first free slot one slot per cycle,
// and its answer can wait on the output; a reload reads the memory, then re-arms; set
// period and delete finish in idle. One item is processed at a time and in_tready is low
// until it is finished. Expiry events come out in slot order, the last one of a tick with
// out_tlast set; a create always answers with one item (handle 0 when full).
module software_timer_table #(
  parameter int SLOTS = stt_pkg::SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [39:0]                  in_tdata,  // handle[3:0], period[35:4],
                                                  // periodic[36], start_active[37], zero
  input  logic [stt_pkg::FUNC_W-1:0]   in_tuser,  // func
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata, // handle_out[3:0], zero
  output logic                         out_tuser, // event_kind
  output logic                         out_tlast
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [6:0] SLOTS_H = 7'(SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SCAN_END,
    S_FIND,
    S_RELOAD_RD,
    S_RELOAD_WR
  } state_t;

  function automatic logic [stt_pkg::HND_W-1:0] to_handle(input logic [IDX_W-1:0] i);
    logic [IDX_W:0] t;
    t = {1'b0, i} + (IDX_W+1)'(1);
    return stt_pkg::HND_W'(t);
  endfunction

  state_t                            state_r, state_nxt;
  logic [IDX_W-1:0]                  idx_r, idx_nxt;
  logic [stt_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic [stt_pkg::CNT_W-1:0]         per_r, per_nxt;
  logic                              periodic_r, periodic_nxt;
  logic                              start_r, start_nxt;
  logic [SLOTS-1:0]                  used_r, used_nxt;
  logic [SLOTS-1:0]                  armed_r, armed_nxt;
  logic [SLOTS-1:0]                  auto_r, auto_nxt;
  logic                              pend_v_r, pend_v_nxt;
  logic [stt_pkg::HND_W-1:0]         pend_h_r, pend_h_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              out_kind_r, out_kind_nxt;
  logic [stt_pkg::HND_W-1:0]         out_h_r, out_h_nxt;
  logic                              out_last_r, out_last_nxt;

  logic [stt_pkg::HND_W-1:0]         in_handle;
  logic [stt_pkg::CNT_W-1:0]         in_period;
  logic [stt_pkg::HND_W-1:0]         hm1;
  logic [IDX_W-1:0]                  hidx;
  logic                              hvalid;
  logic                              out_free;
  logic                              hit;
  logic [stt_pkg::CNT_W-1:0]         addend;
  logic [stt_pkg::CNT_W-1:0]         sum;

  stt_pkg::mem_we_t                  mem_we;
  logic [IDX_W-1:0]                  mem_waddr;
  logic [stt_pkg::CNT_W-1:0]         mem_wper;
  logic [stt_pkg::CNT_W-1:0]         rd_per;
  logic [stt_pkg::CNT_W-1:0]         rd_dl;

  assign in_handle = in_tdata[3:0];
  assign in_period = in_tdata[35:4];
  assign hm1       = in_handle - 4'd1;
  assign hidx      = IDX_W'(hm1);
  assign hvalid    = (in_handle != '0) && ({3'b000, in_handle} <= SLOTS_H);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_h_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  assign out_free = !out_valid_r || out_tready;
  assign hit      = armed_r[idx_r] && (count_r >= rd_dl);

  // single adder for every deadline: count plus a period
  assign addend = (state_r == S_FIND) ? per_r : rd_per;
  assign sum    = count_r + addend;

  assign mem_waddr = (state_r == S_IDLE) ? hidx : idx_r;
  assign mem_wper  = (state_r == S_IDLE) ? in_period : per_r;

  stt_slot_mem #(
    .SLOTS(SLOTS)
  ) u_mem (
    .clk      (clk),
    .we       (mem_we),
    .waddr    (mem_waddr),
    .wdata_per(mem_wper),
    .wdata_dl (sum),
    .raddr    (idx_r),
    .rdata_per(rd_per),
    .rdata_dl (rd_dl)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    per_nxt       = per_r;
    periodic_nxt  = periodic_r;
    start_nxt     = start_r;
    used_nxt      = used_r;
    armed_nxt     = armed_r;
    auto_nxt      = auto_r;
    pend_v_nxt    = pend_v_r;
    pend_h_nxt    = pend_h_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_h_nxt     = out_h_r;
    out_last_nxt  = out_last_r;
    mem_we        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          per_nxt      = in_period;
          periodic_nxt = in_tdata[36];
          start_nxt    = in_tdata[37];
          case (stt_pkg::func_t'(in_tuser))
            stt_pkg::FN_TICK: begin
              count_nxt  = count_r + 32'd1;
              idx_nxt    = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = S_SCAN_RD;
            end
            stt_pkg::FN_CREATE: begin
              idx_nxt   = '0;
              state_nxt = S_FIND;
            end
            stt_pkg::FN_SETPER: begin
              mem_we.per = hvalid;
            end
            stt_pkg::FN_RELOAD: begin
              if (hvalid && used_r[hidx]) begin
                idx_nxt   = hidx;
                state_nxt = S_RELOAD_RD;
              end
            end
            stt_pkg::FN_DELETE: begin
              if (hvalid) begin
                used_nxt[hidx]  = 1'b0;
                armed_nxt[hidx] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN_RD: begin
        state_nxt = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        // an earlier event is held back until we know whether it is the last
        if (!(hit && pend_v_r && !out_free)) begin
          if (hit) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = 1'b1;
              out_h_nxt     = pend_h_r;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt = 1'b1;
            pend_h_nxt = to_handle(idx_r);
            if (auto_r[idx_r]) begin
              mem_we.dl = 1'b1;
            end else begin
              armed_nxt[idx_r] = 1'b0;
            end
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = S_SCAN_END;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_SCAN_RD;
          end
        end
      end

      S_SCAN_END: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b1;
          out_h_nxt     = pend_h_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      S_FIND: begin
        if (!used_r[idx_r]) begin
          if (out_free) begin
            used_nxt[idx_r]  = 1'b1;
            armed_nxt[idx_r] = start_r;
            auto_nxt[idx_r]  = periodic_r;
            mem_we.per       = 1'b1;
            mem_we.dl        = start_r;
            out_valid_nxt    = 1'b1;
            out_kind_nxt     = 1'b0;
            out_h_nxt        = to_handle(idx_r);
            out_last_nxt     = 1'b1;
            state_nxt        = S_IDLE;
          end
        end else if (idx_r == LAST_IDX) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = 1'b0;
            out_h_nxt     = '0;
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_RELOAD_RD: begin
        state_nxt = S_RELOAD_WR;
      end

      S_RELOAD_WR: begin
        mem_we.dl        = 1'b1;
        armed_nxt[idx_r] = 1'b1;
        state_nxt        = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      count_r     <= '0;
      used_r      <= '0;
      armed_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      armed_r     <= armed_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    per_r      <= per_nxt;
    periodic_r <= periodic_nxt;
    start_r    <= start_nxt;
    auto_r     <= auto_nxt;
    pend_h_r   <= pend_h_nxt;
    out_kind_r <= out_kind_nxt;
    out_h_r    <= out_h_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

/* rtl/core/stt_slot_mem.sv */
module stt_slot_mem #(
  parameter int SLOTS = stt_pkg::SLOTS_DEF,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                      clk,
  input  stt_pkg::mem_we_t          we,
  input  logic [IDX_W-1:0]          waddr,
  input  logic [stt_pkg::CNT_W-1:0] wdata_per,
  input  logic [stt_pkg::CNT_W-1:0] wdata_dl,
  input  logic [IDX_W-1:0]          raddr,
  output logic [stt_pkg::CNT_W-1:0] rdata_per,
  output logic [stt_pkg::CNT_W-1:0] rdata_dl
);

  logic [stt_pkg::CNT_W-1:0] per_mem [SLOTS];
  logic [stt_pkg::CNT_W-1:0] dl_mem  [SLOTS];

  always_ff @(posedge clk) begin
    if (we.per) begin
      per_mem[waddr] <= wdata_per;
    end
    if (we.dl) begin
      dl_mem[waddr] <= wdata_dl;
    end
    rdata_per <= per_mem[raddr];
    rdata_dl  <= dl_mem[raddr];
  end

endmodule
